@@ sv/pixel_palette_indexer_defines.svh @@
// Assertion macros used by the palette indexer checker.
`ifndef PIXEL_PALETTE_INDEXER_DEFINES_SVH
`define PIXEL_PALETTE_INDEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define PPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst is high.
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ppi_pkg.sv @@
// Shared constants and the token type that travels along the palette cell chain.
package ppi_pkg;

  // Number of palette cells and stored pixel width.
  localparam int PALETTE_SIZE = 256;
  localparam int PIXEL_BITS   = 32;

  // Width of a palette index inside the chain and on the output port.
  localparam int ID_W  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int OUT_W = 8;

  // Index given to a new value once every cell is taken.
  localparam logic [ID_W-1:0] SATURATED_ID = ID_W'(PALETTE_SIZE - 1);

  // One pixel in flight: the value, the band flag and the search result so far.
  typedef struct packed {
    logic                  vld;
    logic                  band;
    logic                  found;
    logic [PIXEL_BITS-1:0] pixel;
    logic [ID_W-1:0]       id;
  } token_t;

endpackage

@@ sv/ppi_cell.sv @@
// One palette cell: holds one entry and passes the search token to its neighbor.
module ppi_cell
  import ppi_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  token_t tok_in,
  output token_t tok_out
);

  logic                  slot_valid;
  logic [PIXEL_BITS-1:0] entry;
  logic                  live;
  logic                  hit;
  logic                  claim;
  logic                  done;
  token_t                tok;

  // A band start empties the cell before this pixel looks at it.
  assign live  = slot_valid & ~tok_in.band;
  assign hit   = tok_in.vld & ~tok_in.found & live & (entry == tok_in.pixel);
  assign claim = tok_in.vld & ~tok_in.found & ~live;
  assign done  = tok_in.found | hit | claim;

  // Occupancy of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (adv && tok_in.vld) begin
      slot_valid <= live | claim;
    end
  end

  // The first free cell takes a value that no earlier cell holds.
  always_ff @(posedge clk) begin
    if (adv && claim) begin
      entry <= tok_in.pixel;
    end
  end

  // Token register: the valid bit moves with the chain, and the index counts
  // cells passed until the search is settled.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
    end else if (adv) begin
      tok.vld   <= tok_in.vld;
      tok.band  <= tok_in.band;
      tok.pixel <= tok_in.pixel;
      tok.found <= done;
      tok.id    <= done ? tok_in.id : tok_in.id + ID_W'(1);
    end
  end

  assign tok_out = tok;

endmodule

@@ sv/pixel_palette_indexer.sv @@
// Top level of the first-seen palette indexer: a chain of palette cells and an output register.
//
// Input channel: pixel_value and band_start with pixel_valid / pixel_ready.
// Output channel: colour_id with colour_valid / colour_ready.
// Each pixel enters a chain of PALETTE_SIZE cells, one cell per unstalled clock. Every
// cell holds one palette entry; the pixel is matched against it or, at the
// first empty cell, stored there. The index is the number of cells passed.
// A pixel with band_start set empties every cell it passes before using it,
// so it always gets index 0 and later pixels see only the new band.
// A new value arriving when all cells are taken gets index PALETTE_SIZE-1.
// Throughput: one pixel per clock while not stalled; several pixels travel down the chain at once.
// The result passes through the register of every cell in the chain and
// then through the output register.
// When the receiver stalls, the whole chain and the output register hold and
// pixel_ready drops; nothing is lost or reordered.
// Reset (rst, synchronous) empties every cell and drops all items in flight.
module pixel_palette_indexer
  import ppi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      pixel_value,
  input  logic             band_start,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  output logic [OUT_W-1:0] colour_id,
  output logic             colour_valid,
  input  logic             colour_ready
);

  token_t           tok [PALETTE_SIZE+1];
  logic             adv;
  logic [ID_W-1:0]  final_id;
  logic             out_valid;
  logic [OUT_W-1:0] out_id;

  // The chain moves whenever the output register is free or being emptied.
  assign adv         = ~out_valid | colour_ready;
  assign pixel_ready = adv;

  // Token entering the first cell.
  assign tok[0].vld   = pixel_valid;
  assign tok[0].band  = band_start;
  assign tok[0].found = 1'b0;
  assign tok[0].pixel = pixel_value[PIXEL_BITS-1:0];
  assign tok[0].id    = '0;

  // Row of palette cells.
  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    ppi_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // A value that found neither a match nor a free cell saturates.
  assign final_id = tok[PALETTE_SIZE].found ? tok[PALETTE_SIZE].id : SATURATED_ID;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tok[PALETTE_SIZE].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_id <= OUT_W'(final_id);
    end
  end

  assign colour_valid = out_valid;
  assign colour_id    = out_id;

endmodule

@@ sv/ppi_checker.sv @@
// Port-level checker for the palette indexer, bound to the top level.
`include "pixel_palette_indexer_defines.svh"

module ppi_checker
  import ppi_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pixel_ready,
  input logic [OUT_W-1:0] colour_id,
  input logic             colour_valid,
  input logic             colour_ready
);

  // A stalled result stays on the port unchanged.
  `PPI_ASSERT_NEXT(a_out_hold, colour_valid && !colour_ready, colour_valid && $stable(colour_id), "colour transaction changed while stalled")

  // With the output register empty, the block must take a pixel.
  `PPI_ASSERT_NOW(a_ready_when_empty, !colour_valid, pixel_ready, "pixel_ready low with empty output")

  // A result being taken frees room for a new pixel in the same cycle.
  `PPI_ASSERT_NOW(a_ready_on_drain, colour_valid && colour_ready, pixel_ready, "pixel_ready low while output drains")

  // Reset leaves no result on the port.
  `PPI_ASSERT_NOW(a_reset_empty, $past(rst), !colour_valid, "result shown right after reset")

endmodule

bind pixel_palette_indexer ppi_checker u_ppi_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_ready  (pixel_ready),
  .colour_id    (colour_id),
  .colour_valid (colour_valid),
  .colour_ready (colour_ready)
);
